@@ rtl/core/smdu_pkg.sv @@
// ----------------------------------------------------------------------------
// smdu_pkg
// operation codes and shared types for the simd multiply/divide unit
// ----------------------------------------------------------------------------
package smdu_pkg;

  typedef enum logic [3:0] {
    OP_DIV     = 4'd0,
    OP_DIVU    = 4'd1,
    OP_MULT    = 4'd2,
    OP_MULTU   = 4'd3,
    OP_PDIVBW  = 4'd4,
    OP_PDIVUW  = 4'd5,
    OP_PDIVW   = 4'd6,
    OP_PMULTH  = 4'd7,
    OP_PMULTUW = 4'd8,
    OP_PMULTW  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  localparam int unsigned LANES = 4;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEPS = 32;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

  // per-lane setup for the serial datapath
  typedef struct packed {
    logic        is_div;
    logic        sgn_a;
    logic        sgn_b;
  } lane_mode_t;

endpackage

@@ rtl/core/smdu_lane.sv @@
// ----------------------------------------------------------------------------
// smdu_lane
// one radix-2 lane, while step is high: shift-add multiply or restoring divide, one bit per cycle
// ----------------------------------------------------------------------------
module smdu_lane (
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  smdu_pkg::lane_mode_t mode,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output logic [63:0]         prod,
  output logic [31:0]         quo,
  output logic [31:0]         rem,
  output logic                dz
);

  logic [31:0] mb_r, mb_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_q_r, neg_r_r, neg_p_r, div_r, dz_r;
  logic [31:0] abs_a, abs_b;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] q_raw, r_raw;

  assign abs_a = (mode.sgn_a && a[31]) ? (~a + 32'd1) : a;
  assign abs_b = (mode.sgn_b && b[31]) ? (~b + 32'd1) : b;

  // multiply: acc = {hi, lo}; lo holds multiplier bits shifting out
  // divide: acc = {rem, quo}
  assign sum  = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, mb_r} : 33'd0);
  assign diff = {acc_r[63:31]} - {1'b0, mb_r};

  always_comb begin
    mb_nxt  = mb_r;
    acc_nxt = acc_r;
    if (load) begin
      mb_nxt  = abs_b;
      acc_nxt = {32'd0, abs_a};
    end else if (step) begin
      if (div_r) begin
        if (!diff[32]) acc_nxt = {diff[31:0], acc_r[30:0], 1'b1};
        else           acc_nxt = {acc_r[62:0], 1'b0};
      end else begin
        acc_nxt = {sum, acc_r[31:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    if (load) begin
      div_r   <= mode.is_div;
      neg_q_r <= (mode.sgn_a && a[31]) ^ (mode.sgn_b && b[31]);
      neg_r_r <= mode.sgn_a && a[31];
      neg_p_r <= (mode.sgn_a && a[31]) ^ (mode.sgn_b && b[31]);
      dz_r    <= (b == 32'd0);
    end
  end

  assign q_raw = acc_r[31:0];
  assign r_raw = acc_r[63:32];
  assign quo   = neg_q_r ? (~q_raw + 32'd1) : q_raw;
  assign rem   = neg_r_r ? (~r_raw + 32'd1) : r_raw;
  assign prod  = neg_p_r ? (~acc_r + 64'd1) : acc_r;
  assign dz    = dz_r;

endmodule

@@ rtl/core/smdu_ctrl.sv @@
// ----------------------------------------------------------------------------
// smdu_ctrl
// sequencer: accepts a beat, counts 32 serial steps, holds the result beat
// ----------------------------------------------------------------------------
module smdu_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  output logic in_rdy,
  output logic load,
  output logic step,
  output logic fin,
  output logic out_vld
);

  smdu_pkg::state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      smdu_pkg::ST_IDLE: if (in_fire) state_nxt = smdu_pkg::ST_RUN;
      smdu_pkg::ST_RUN:  if (cnt_r == 6'd32) state_nxt = smdu_pkg::ST_DONE;
      smdu_pkg::ST_DONE: if (out_fire) state_nxt = smdu_pkg::ST_IDLE;
      default:           state_nxt = smdu_pkg::ST_IDLE;
    endcase
  end

  // the lanes step while running, then fin captures the lane results
  always_comb begin
    in_rdy  = 1'b0;
    step    = 1'b0;
    out_vld = 1'b0;
    fin     = 1'b0;
    cnt_nxt = cnt_r;
    unique case (state_r)
      smdu_pkg::ST_IDLE: begin
        in_rdy  = 1'b1;
        cnt_nxt = 6'd0;
      end
      smdu_pkg::ST_RUN: begin
        step    = (cnt_r != 6'd32);
        cnt_nxt = cnt_r + 6'd1;
        fin     = (cnt_r == 6'd32);
      end
      smdu_pkg::ST_DONE: out_vld = 1'b1;
      default: ;
    endcase
  end

  assign load = in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smdu_pkg::ST_IDLE;
      cnt_r   <= 6'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/core/simd_integer_mul_div_unit.sv @@
// ----------------------------------------------------------------------------
// simd_integer_mul_div_unit
// scalar and parallel 32-bit multiply/divide with 128-bit lo and hi registers
// ----------------------------------------------------------------------------
// one beat at a time: a new input beat is accepted only once the result beat
// has been taken; four radix-2 lanes each retire one product or quotient bit
// per cycle while the sequencer steps them
// reset: synchronous active-low rst_n clears the sequencer and lo/hi to zero
module simd_integer_mul_div_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[3:0], rs_low, rs_high, rt_low, rt_high (from bit 0 up), zero-padded
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rd_low, rd_high, rd_write[1:0], lo_low, lo_high, hi_low, hi_high, padded
  output logic [391:0] out_tdata
);

  logic [3:0]  cmd_r;
  logic [63:0] lo_r [2];
  logic [63:0] hi_r [2];
  logic [63:0] rd_r [2];
  logic [1:0]  wr_r;
  logic        load, step, fin, in_fire, out_fire;
  logic [3:0]  cmd_in;
  logic [31:0] wa [4];
  logic [31:0] wb [4];
  logic [63:0] prod [4];
  logic [31:0] quo [4];
  logic [31:0] rem [4];
  logic [3:0]  dz;
  smdu_pkg::lane_mode_t mode [4];
  logic [63:0] lo_nxt [2];
  logic [63:0] hi_nxt [2];
  logic [63:0] rd_nxt [2];
  logic [1:0]  wr_nxt;
  logic [31:0] h [8];

  assign cmd_in  = in_tdata[3:0];
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  smdu_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire,
    .in_rdy(in_tready), .load, .step, .fin, .out_vld(out_tvalid)
  );

  // lane operand select; for pmulth the lane results go unused and the halfword products are formed separately
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wa[i] = in_tdata[4 + 32*i +: 32];
      wb[i] = in_tdata[132 + 32*i +: 32];
      mode[i] = '0;
    end
    unique case (cmd_in)
      smdu_pkg::OP_DIV, smdu_pkg::OP_PDIVW: begin
        for (int i = 0; i < 4; i++) mode[i] = '{1'b1, 1'b1, 1'b1};
      end
      smdu_pkg::OP_DIVU, smdu_pkg::OP_PDIVUW: begin
        for (int i = 0; i < 4; i++) mode[i] = '{1'b1, 1'b0, 1'b0};
      end
      smdu_pkg::OP_PDIVBW: begin
        for (int i = 0; i < 4; i++) begin
          mode[i] = '{1'b1, 1'b1, 1'b1};
          wb[i] = {{16{in_tdata[147]}}, in_tdata[147:132]};
        end
      end
      smdu_pkg::OP_MULT, smdu_pkg::OP_PMULTW: begin
        for (int i = 0; i < 4; i++) mode[i] = '{1'b0, 1'b1, 1'b1};
      end
      smdu_pkg::OP_PMULTH: begin
        // lanes still get the full words, unsigned; their products are not used
        for (int i = 0; i < 4; i++) begin
          mode[i] = '{1'b0, 1'b0, 1'b0};
          wa[i] = in_tdata[4 + 32*i +: 32];
          wb[i] = in_tdata[132 + 32*i +: 32];
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) mode[i] = '{1'b0, 1'b0, 1'b0};
      end
    endcase
  end

  // operation code held for the finish cycle
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_in;
    end
  end

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_lane
      smdu_lane u_lane (
        .clk, .load, .step, .mode(mode[g]), .a(wa[g]), .b(wb[g]),
        .prod(prod[g]), .quo(quo[g]), .rem(rem[g]), .dz(dz[g])
      );
    end
  endgenerate

  // pmulth halfword products from the operands captured at load
  logic [15:0] ha_r [8];
  logic [15:0] hb_r [8];
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) begin
        ha_r[i] <= in_tdata[4 + 16*i +: 16];
        hb_r[i] <= in_tdata[132 + 16*i +: 16];
      end
    end
  end
  always_comb begin
    for (int i = 0; i < 8; i++)
      h[i] = 32'($signed(ha_r[i]) * $signed(hb_r[i]));
  end

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    rd_nxt = '{64'd0, 64'd0};
    wr_nxt = 2'd0;
    case (cmd_r)
      smdu_pkg::OP_DIV: begin
        if (!dz[0]) begin
          lo_nxt[0] = {{32{quo[0][31]}}, quo[0]};
          hi_nxt[0] = {{32{rem[0][31]}}, rem[0]};
        end
      end
      smdu_pkg::OP_PDIVW: begin
        for (int d = 0; d < 2; d++) if (!dz[2*d]) begin
          lo_nxt[d] = {{32{quo[2*d][31]}}, quo[2*d]};
          hi_nxt[d] = {{32{rem[2*d][31]}}, rem[2*d]};
        end
      end
      smdu_pkg::OP_DIVU: begin
        if (!dz[0]) begin
          lo_nxt[0] = {32'd0, quo[0]};
          hi_nxt[0] = {32'd0, rem[0]};
        end
      end
      smdu_pkg::OP_PDIVUW: begin
        for (int d = 0; d < 2; d++) if (!dz[2*d]) begin
          lo_nxt[d] = {32'd0, quo[2*d]};
          hi_nxt[d] = {32'd0, rem[2*d]};
        end
      end
      smdu_pkg::OP_PDIVBW: begin
        for (int i = 0; i < 4; i++) if (!dz[i]) begin
          lo_nxt[i/2][32*(i%2) +: 32] = quo[i];
          hi_nxt[i/2][32*(i%2) +: 32] = rem[i];
        end
      end
      smdu_pkg::OP_MULT: begin
        lo_nxt[0] = {{32{prod[0][31]}}, prod[0][31:0]};
        hi_nxt[0] = {{32{prod[0][63]}}, prod[0][63:32]};
        rd_nxt[0] = lo_nxt[0];
        wr_nxt = 2'd1;
      end
      smdu_pkg::OP_MULTU: begin
        lo_nxt[0] = {32'd0, prod[0][31:0]};
        hi_nxt[0] = {32'd0, prod[0][63:32]};
        rd_nxt[0] = lo_nxt[0];
        wr_nxt = 2'd1;
      end
      smdu_pkg::OP_PMULTW: begin
        for (int d = 0; d < 2; d++) begin
          lo_nxt[d] = {{32{prod[2*d][31]}}, prod[2*d][31:0]};
          hi_nxt[d] = {{32{prod[2*d][63]}}, prod[2*d][63:32]};
          rd_nxt[d] = prod[2*d];
        end
        wr_nxt = 2'd3;
      end
      smdu_pkg::OP_PMULTUW: begin
        for (int d = 0; d < 2; d++) begin
          lo_nxt[d] = {32'd0, prod[2*d][31:0]};
          hi_nxt[d] = {32'd0, prod[2*d][63:32]};
          rd_nxt[d] = prod[2*d];
        end
        wr_nxt = 2'd3;
      end
      smdu_pkg::OP_PMULTH: begin
        rd_nxt[0] = {h[2], h[0]};
        rd_nxt[1] = {h[6], h[4]};
        lo_nxt[0] = {h[1], h[0]};
        lo_nxt[1] = {h[5], h[4]};
        hi_nxt[0] = {h[3], h[2]};
        hi_nxt[1] = {h[7], h[6]};
        wr_nxt = 2'd3;
      end
      default: ;
    endcase
  end

  // signed minimum by minus one: the serial divider already yields quotient
  // 0x80000000 and remainder 0 after negation, so no fix-up is needed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '{64'd0, 64'd0};
      hi_r <= '{64'd0, 64'd0};
    end else if (fin) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
  end

  assign out_tdata = {6'd0, hi_r[1], hi_r[0], lo_r[1], lo_r[0], wr_r, rd_r[1], rd_r[0]};

endmodule

@@ rtl/core/smdu_checker.sv @@
// ----------------------------------------------------------------------------
// smdu_sva
// port-level checks for the simd multiply/divide unit
// ----------------------------------------------------------------------------
module smdu_sva (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [391:0] out_tdata
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept while result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[391:386] == 6'd0) else $error("pad bits set");

endmodule

bind simd_integer_mul_div_unit smdu_sva u_smdu_sva (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

@@ sim/smdu_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smdu_checker
// watches both streams of the multiply/divide unit, predicts each result beat
// from its own copy of lo/hi and compares whole beats in order
// ----------------------------------------------------------------------------
module smdu_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [263:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [391:0] out_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [63:0] hi_high;
    logic [63:0] hi_low;
    logic [63:0] lo_high;
    logic [63:0] lo_low;
    logic [1:0]  rd_write;
    logic [63:0] rd_high;
    logic [63:0] rd_low;
  } mdu_result_t;

  logic [63:0] lo_reg [2];
  logic [63:0] hi_reg [2];
  mdu_result_t result_q[$];

  assign pending = result_q.size();

  function automatic logic [31:0] word_sel(logic [63:0] l, logic [63:0] h, int i);
    logic [127:0] v;
    v = {h, l};
    return v[i*32 +: 32];
  endfunction

  // signed 32-bit divide, false on zero divisor
  function automatic bit sdiv32(logic signed [63:0] a, logic signed [63:0] b,
                                output logic [31:0] q, output logic [31:0] r);
    logic signed [63:0] qq, rr;
    q = '0;
    r = '0;
    if (a == -64'sd2147483648 && b == -64'sd1) begin
      q = 32'h8000_0000;
      return 1;
    end
    if (b == 0) return 0;
    qq = a / b;
    rr = a % b;
    q = qq[31:0];
    r = rr[31:0];
    return 1;
  endfunction

  task automatic predict_beat(logic [263:0] d);
    logic [3:0] op;
    logic [63:0] sl, sh, tl, th, p;
    logic [63:0] rd [2];
    logic [1:0] wr;
    logic [31:0] a, b, q, r;
    logic [127:0] lo_v, hi_v, rd_v, s_v, t_v;
    logic signed [31:0] ps;
    logic signed [63:0] dv;
    mdu_result_t res;
    op = d[3:0];
    sl = d[67:4];
    sh = d[131:68];
    tl = d[195:132];
    th = d[259:196];
    rd[0] = '0;
    rd[1] = '0;
    wr = '0;
    case (op)
      smdu_pkg::OP_DIV, smdu_pkg::OP_PDIVW: begin
        for (int i = 0; i < 4; i += 2) begin
          a = word_sel(sl, sh, i);
          b = word_sel(tl, th, i);
          if (sdiv32(64'($signed(a)), 64'($signed(b)), q, r)) begin
            lo_reg[i/2] = 64'($signed(q));
            hi_reg[i/2] = 64'($signed(r));
          end
          if (op == smdu_pkg::OP_DIV) break;
        end
      end
      smdu_pkg::OP_DIVU, smdu_pkg::OP_PDIVUW: begin
        for (int i = 0; i < 4; i += 2) begin
          a = word_sel(sl, sh, i);
          b = word_sel(tl, th, i);
          if (b != 0) begin
            lo_reg[i/2] = 64'(a / b);
            hi_reg[i/2] = 64'(a % b);
          end
          if (op == smdu_pkg::OP_DIVU) break;
        end
      end
      smdu_pkg::OP_MULT, smdu_pkg::OP_MULTU, smdu_pkg::OP_PMULTUW, smdu_pkg::OP_PMULTW: begin
        for (int i = 0; i < 4; i += 2) begin
          a = word_sel(sl, sh, i);
          b = word_sel(tl, th, i);
          if (op == smdu_pkg::OP_MULT || op == smdu_pkg::OP_PMULTW) begin
            p = 64'($signed(a)) * 64'($signed(b));
            lo_reg[i/2] = 64'($signed(p[31:0]));
            hi_reg[i/2] = 64'($signed(p[63:32]));
          end else begin
            p = 64'(a) * 64'(b);
            lo_reg[i/2] = 64'(p[31:0]);
            hi_reg[i/2] = 64'(p[63:32]);
          end
          if (op == smdu_pkg::OP_MULT || op == smdu_pkg::OP_MULTU) begin
            rd[0] = lo_reg[0];
            wr = 2'd1;
            break;
          end
          rd[i/2] = p;
          wr = 2'd3;
        end
      end
      smdu_pkg::OP_PDIVBW: begin
        dv = 64'($signed(tl[15:0]));
        lo_v = {lo_reg[1], lo_reg[0]};
        hi_v = {hi_reg[1], hi_reg[0]};
        for (int i = 0; i < 4; i++) begin
          if (sdiv32(64'($signed(word_sel(sl, sh, i))), dv, q, r)) begin
            lo_v[i*32 +: 32] = q;
            hi_v[i*32 +: 32] = r;
          end
        end
        {lo_reg[1], lo_reg[0]} = lo_v;
        {hi_reg[1], hi_reg[0]} = hi_v;
      end
      smdu_pkg::OP_PMULTH: begin
        lo_v = {lo_reg[1], lo_reg[0]};
        hi_v = {hi_reg[1], hi_reg[0]};
        rd_v = '0;
        s_v = {sh, sl};
        t_v = {th, tl};
        for (int i = 0; i < 8; i++) begin
          ps = $signed(s_v[i*16 +: 16]) * $signed(t_v[i*16 +: 16]);
          if (i % 2 == 0) rd_v[(i/2)*32 +: 32] = ps;
          if (i & 2) hi_v[((i & 1) | ((i >> 1) & 2))*32 +: 32] = ps;
          else lo_v[((i & 1) | ((i >> 1) & 2))*32 +: 32] = ps;
        end
        {lo_reg[1], lo_reg[0]} = lo_v;
        {hi_reg[1], hi_reg[0]} = hi_v;
        {rd[1], rd[0]} = rd_v;
        wr = 2'd3;
      end
      default: ;
    endcase
    res.rd_low = rd[0];
    res.rd_high = rd[1];
    res.rd_write = wr;
    res.lo_low = lo_reg[0];
    res.lo_high = lo_reg[1];
    res.hi_low = hi_reg[0];
    res.hi_high = hi_reg[1];
    result_q.push_back(res);
  endtask

  task automatic compare_beat(mdu_result_t got);
    mdu_result_t exp_r;
    if (result_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result beat %h", got);
      return;
    end
    exp_r = result_q.pop_front();
    if (got !== exp_r) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: exp rd %h_%h wr %0d lo %h_%h hi %h_%h", exp_r.rd_high,
                 exp_r.rd_low, exp_r.rd_write, exp_r.lo_high, exp_r.lo_low,
                 exp_r.hi_high, exp_r.hi_low);
        $display("          got rd %h_%h wr %0d lo %h_%h hi %h_%h", got.rd_high,
                 got.rd_low, got.rd_write, got.lo_high, got.lo_low,
                 got.hi_high, got.hi_low);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lo_reg[0] = '0;
      lo_reg[1] = '0;
      hi_reg[0] = '0;
      hi_reg[1] = '0;
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) compare_beat(out_tdata[385:0]);
      if (in_tvalid && in_tready) predict_beat(in_tdata);
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random beats of every operation into the multiply/divide
// unit with random idle bursts on both sides; the checker judges the results
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RANDOM_BEATS = 1830;
  localparam int CYCLE_LIMIT = 600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [263:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [391:0] out_tdata;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  int           beats_sent = 0;
  bit           calm = 1'b0;

  always #6 clk = ~clk;

  simd_integer_mul_div_unit dut (.*);

  smdu_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    @(negedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (!calm) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h1;
      5: return 32'(signed'($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] pick_dword();
    return {pick_word(), pick_word()};
  endfunction

  task automatic send_beat(logic [3:0] op, logic [63:0] sl, logic [63:0] sh,
                           logic [63:0] tl, logic [63:0] th);
    in_tdata <= {4'd0, th, tl, sh, sl, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    beats_sent++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  initial begin
    logic [3:0] op;
    logic [63:0] tl;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed corners, each operation
    send_beat(smdu_pkg::OP_DIV, 64'h8000_0000, 0, 64'hFFFF_FFFF, 0);
    send_beat(smdu_pkg::OP_DIV, 64'h1234_5678, 0, 64'h0, 0);
    send_beat(smdu_pkg::OP_DIV, 64'hFFFF_FFF9, 0, 64'h2, 0);
    send_beat(smdu_pkg::OP_DIVU, 64'hFFFF_FFFF, 0, 64'h3, 0);
    send_beat(smdu_pkg::OP_DIVU, 64'h5, 0, 64'h0, 0);
    send_beat(smdu_pkg::OP_MULT, 64'h8000_0000, 0, 64'h8000_0000, 0);
    send_beat(smdu_pkg::OP_MULT, 64'hFFFF_FFFF, 0, 64'h7FFF_FFFF, 0);
    send_beat(smdu_pkg::OP_MULTU, '1, '1, '1, '1);
    send_beat(smdu_pkg::OP_PDIVBW, {32'h8000_0000, 32'h7FFF_FFFF},
              {32'hFFFF_FFFF, 32'h8000_0000}, 64'hFFFF, 0);
    send_beat(smdu_pkg::OP_PDIVBW, '1, '1, 64'hFFFF_0000, '1);
    send_beat(smdu_pkg::OP_PDIVBW, 64'h1_0000_0064, 64'hFFFF_FF9C, 64'h8000, 0);
    send_beat(smdu_pkg::OP_PDIVUW, '1, '1, 64'h7, 0);
    send_beat(smdu_pkg::OP_PDIVW, 64'h8000_0000, 64'h8000_0000, 64'hFFFF_FFFF,
              64'hFFFF_FFFF);
    send_beat(smdu_pkg::OP_PDIVW, 64'h64, 64'hFFFF_FF9C, 64'h0, 64'h7);
    send_beat(smdu_pkg::OP_PMULTH, 64'h8000_7FFF_FFFF_8000, '1,
              64'h8000_8000_7FFF_FFFF, '1);
    send_beat(smdu_pkg::OP_PMULTUW, '1, '1, '1, '1);
    send_beat(smdu_pkg::OP_PMULTW, 64'h8000_0000, 64'h7FFF_FFFF, 64'h8000_0000,
              64'hFFFF_FFFF);
    send_beat(4'd10, '1, '1, '1, '1);
    send_beat(4'd15, 0, 0, 0, 0);
    send_beat(smdu_pkg::OP_MULT, 0, 0, 0, 0);
    // random beats, quiet handshakes for the last stretch
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - 150) calm = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                        : 4'($urandom_range(0, 9));
      tl = pick_dword();
      if (op == smdu_pkg::OP_PDIVBW && $urandom_range(0, 3) == 0)
        tl[15:0] = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0;
      send_beat(op, ($urandom_range(0, 1)) ? {$urandom, $urandom} : pick_dword(),
                pick_dword(), tl, pick_dword());
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    $display("sent %0d beats covering all ten operations, unused codes,", beats_sent);
    $display("signed overflow and zero divisors with random stalls on both sides");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
